/* rtl/tvpc_pkg.sv */
package tvpc_pkg;

  localparam int AngW     = 9;
  localparam int TravW    = 8;
  localparam int TimeW    = 18;
  localparam int ProdW    = 28;
  localparam int MulW     = 18;
  localparam int DivNumW  = ProdW;
  localparam int DivDenW  = TimeW;
  localparam int DivCntW  = $clog2(DivNumW);

  localparam logic [DivCntW-1:0] DivLast   = DivCntW'(DivNumW - 1);
  localparam logic [TimeW-1:0]   TimeMax   = {TimeW{1'b1}};
  localparam logic [MulW-1:0]    TicksPerSec = MulW'(1000);
  localparam logic [AngW-1:0]    CalExtraSec = AngW'(2);

  localparam logic [AngW-1:0]  StartReset  = AngW'(0);
  localparam logic [AngW-1:0]  MaxReset    = AngW'(90);
  localparam logic [TravW-1:0] TravelReset = TravW'(30);

  typedef enum logic [2:0] {
    CmdTick      = 3'd0,
    CmdOpen      = 3'd1,
    CmdClose     = 3'd2,
    CmdHalf      = 3'd3,
    CmdSetTarget = 3'd4,
    CmdCalibrate = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    StatCal    = 3'd0,
    StatMoving = 3'd1,
    StatOpen   = 3'd2,
    StatHalf   = 3'd3,
    StatClosed = 3'd4,
    StatOther  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RegStart  = 2'd0,
    RegMax    = 2'd1,
    RegTravel = 2'd2,
    RegCalCw  = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StLim,
    StCal,
    StMul1,
    StMul2,
    StDurGo,
    StDurWait,
    StDur,
    StMul3,
    StEstGo,
    StEstWait,
    StOut
  } state_e;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

  // start + (max - start) / 2, quotient truncated toward zero
  function automatic logic [AngW-1:0] half_angle(input logic [AngW-1:0] s,
                                                 input logic [AngW-1:0] m);
    logic signed [AngW:0] d;
    logic signed [AngW:0] h;
    d = $signed({1'b0, m}) - $signed({1'b0, s});
    h = (d + $signed({{AngW{1'b0}}, d[AngW]})) >>> 1;
    return s + h[AngW-1:0];
  endfunction

endpackage

/* rtl/tvpc_div.sv */
module tvpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tvpc_pkg::div_req_t req_i,
  output tvpc_pkg::div_rsp_t rsp_o
);
  import tvpc_pkg::*;

  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   shifted;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[DivNumW-1]};
    trial   = shifted - {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivDenW]) begin
        rem_d = trial[DivDenW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivDenW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* rtl/timed_valve_position_controller.sv */
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  cmd_i, requested_angle_i
// out      output     out_valid_o / out_stall_i drives, angles, flags, status_code_o
// cfg      input      APB (psel, penable ...)  four registers at 4*index
//
// One word at a time: in_stall_o is high from acceptance until the result is
// loaded into the output register. A timed run adds further steps on the shared
// multiplier and up to two passes of the radix-2 divider (run duration, then
// interpolated angle). A pending output word does not block acceptance of the
// next word; the sequencer holds in its last step until the output register is
// free. Reset clears state and loads register defaults; no clearing pass.
module timed_valve_position_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      cmd_i,
  input  logic [tvpc_pkg::AngW-1:0]       requested_angle_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            open_drive_o,
  output logic                            close_drive_o,
  output logic [tvpc_pkg::AngW-1:0]       position_angle_o,
  output logic [tvpc_pkg::AngW-1:0]       estimated_angle_o,
  output logic [tvpc_pkg::AngW-1:0]       goal_angle_o,
  output logic                            moving_o,
  output logic                            is_opening_o,
  output logic                            is_closing_o,
  output logic                            is_calibrating_o,
  output logic [2:0]                      status_code_o
);
  import tvpc_pkg::*;

  // configuration
  logic [AngW-1:0]  start_q, max_q;
  logic [TravW-1:0] travel_q;
  logic             calcw_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  // controller state
  state_e           state_q, state_d;
  logic [2:0]       cmd_q, cmd_d;
  logic [AngW-1:0]  req_q, req_d;
  logic [AngW-1:0]  settled_q, settled_d;
  logic [AngW-1:0]  target_q, target_d;
  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic             motion_q, motion_d;
  logic             dopen_q, dopen_d;
  logic             dclose_q, dclose_d;
  logic             calib_q, calib_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [TimeW-1:0] dur_q, dur_d;
  logic [AngW-1:0]  amt_q, amt_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             open_q, close_q, moving_q, opening_q, closing_q, calibrating_q;
  logic [AngW-1:0]  pos_q, est_q, goal_q;
  logic [2:0]       status_q;
  logic             out_load;

  // shared arithmetic
  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [AngW-1:0]   diff, range_ang, half, req_clamp, est_val;
  logic signed [AngW+1:0] est_v, tgt_s;
  logic [TimeW-1:0]  dur_sat;
  status_e           status_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      RegStart:  prdata = {{(32-AngW){1'b0}}, start_q};
      RegMax:    prdata = {{(32-AngW){1'b0}}, max_q};
      RegTravel: prdata = {{(32-TravW){1'b0}}, travel_q};
      RegCalCw:  prdata = {31'd0, calcw_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= StartReset;
      max_q    <= MaxReset;
      travel_q <= TravelReset;
      calcw_q  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegStart:  start_q  <= pwdata[AngW-1:0];
        RegMax:    max_q    <= pwdata[AngW-1:0];
        RegTravel: travel_q <= pwdata[TravW-1:0];
        RegCalCw:  calcw_q  <= pwdata[0];
        default:   ;
      endcase
    end
  end

  assign diff      = (settled_q > target_q) ? settled_q - target_q : target_q - settled_q;
  assign range_ang = (max_q > start_q) ? max_q - start_q : start_q - max_q;
  assign half      = half_angle(start_q, max_q);
  assign req_clamp = (req_q < start_q) ? start_q : ((req_q > max_q) ? max_q : req_q);
  assign dur_sat   = (|div_rsp.quo[ProdW-1:TimeW]) ? TimeMax : div_rsp.quo[TimeW-1:0];

  assign mul_p = mul_a * mul_b;

  tvpc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // interpolated angle, clamped so that it does not pass the target
  always_comb begin
    tgt_s = $signed({2'b00, target_q});
    if (dopen_q) begin
      est_v = $signed({2'b00, settled_q}) - $signed({2'b00, amt_q});
      if (est_v < tgt_s) est_v = tgt_s;
    end else begin
      est_v = $signed({2'b00, settled_q}) + $signed({2'b00, amt_q});
      if (est_v > tgt_s) est_v = tgt_s;
    end
    est_val = motion_q ? est_v[AngW-1:0] : settled_q;
  end

  always_comb begin
    if (calib_q)                 status_val = StatCal;
    else if (motion_q)           status_val = StatMoving;
    else if (settled_q == start_q) status_val = StatOpen;
    else if (settled_q == half)  status_val = StatHalf;
    else if (settled_q == max_q) status_val = StatClosed;
    else                         status_val = StatOther;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    req_d       = req_q;
    settled_d   = settled_q;
    target_d    = target_q;
    elapsed_d   = elapsed_q;
    motion_d    = motion_q;
    dopen_d     = dopen_q;
    dclose_d    = dclose_q;
    calib_d     = calib_q;
    prod_d      = prod_q;
    dur_d       = dur_q;
    amt_d       = amt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          req_d   = requested_angle_i;
          state_d = StLim;
          case (cmd_i)
            CmdTick: begin
              if ((motion_q || calib_q) && elapsed_q != TimeMax) begin
                elapsed_d = elapsed_q + TimeW'(1);
              end
              if (!motion_q && !calib_q && settled_q != target_q) begin
                dopen_d   = settled_q > target_q;
                dclose_d  = !(settled_q > target_q);
                motion_d  = 1'b1;
                elapsed_d = '0;
              end
            end
            CmdOpen:  if (settled_q != start_q) target_d = start_q;
            CmdClose: if (settled_q != max_q) target_d = max_q;
            CmdHalf:  if (settled_q != half) target_d = half;
            CmdSetTarget: begin
              // clamp happens next cycle, from the held word
            end
            CmdCalibrate: begin
              motion_d  = 1'b0;
              dopen_d   = 1'b0;
              dclose_d  = 1'b0;
              calib_d   = 1'b1;
              elapsed_d = '0;
            end
            default: ;
          endcase
        end
      end
      StLim: begin
        if (cmd_q == CmdSetTarget && req_q != target_q) target_d = req_clamp;
        mul_a   = MulW'({1'b0, travel_q} + CalExtraSec);
        mul_b   = TicksPerSec;
        prod_d  = mul_p[ProdW-1:0];
        state_d = StCal;
      end
      StCal: begin
        if (calib_q && cmd_q == CmdTick && elapsed_q >= prod_q[TimeW-1:0]) begin
          calib_d   = 1'b0;
          settled_d = calcw_q ? start_q : max_q;
        end
        state_d = motion_q ? StMul1 : StOut;
      end
      StMul1: begin
        mul_a   = MulW'(diff);
        mul_b   = MulW'(travel_q);
        prod_d  = mul_p[ProdW-1:0];
        state_d = StMul2;
      end
      StMul2: begin
        mul_a   = prod_q[MulW-1:0];
        mul_b   = TicksPerSec;
        prod_d  = mul_p[ProdW-1:0];
        state_d = StDurGo;
      end
      StDurGo: begin
        if (range_ang == '0) begin
          dur_d   = '0;
          state_d = StDur;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = prod_q;
          div_req.den   = DivDenW'(range_ang);
          state_d       = StDurWait;
        end
      end
      StDurWait: begin
        if (div_rsp.done) begin
          dur_d   = dur_sat;
          state_d = StDur;
        end
      end
      StDur: begin
        if (elapsed_q >= dur_q) begin
          amt_d = diff;
          if (cmd_q == CmdTick) begin
            // run is over: settle at the target
            motion_d  = 1'b0;
            dopen_d   = 1'b0;
            dclose_d  = 1'b0;
            settled_d = target_q;
          end
          state_d = StOut;
        end else begin
          state_d = StMul3;
        end
      end
      StMul3: begin
        mul_a   = elapsed_q;
        mul_b   = MulW'(diff);
        prod_d  = mul_p[ProdW-1:0];
        state_d = StEstGo;
      end
      StEstGo: begin
        div_req.start = 1'b1;
        // round up while opening
        div_req.num   = prod_q + (dopen_q ? ProdW'(dur_q - TimeW'(1)) : '0);
        div_req.den   = dur_q;
        state_d       = StEstWait;
      end
      StEstWait: begin
        if (div_rsp.done) begin
          amt_d   = div_rsp.quo[AngW-1:0];
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      settled_q   <= '0;
      target_q    <= '0;
      elapsed_q   <= '0;
      motion_q    <= 1'b0;
      dopen_q     <= 1'b0;
      dclose_q    <= 1'b0;
      calib_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      settled_q   <= settled_d;
      target_q    <= target_d;
      elapsed_q   <= elapsed_d;
      motion_q    <= motion_d;
      dopen_q     <= dopen_d;
      dclose_q    <= dclose_d;
      calib_q     <= calib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    req_q  <= req_d;
    prod_q <= prod_d;
    dur_q  <= dur_d;
    amt_q  <= amt_d;
    if (out_load) begin
      open_q        <= (motion_q && dopen_q) || (calib_q && calcw_q);
      close_q       <= (motion_q && dclose_q) || (calib_q && !calcw_q);
      pos_q         <= settled_q;
      est_q         <= est_val;
      goal_q        <= target_q;
      moving_q      <= motion_q;
      opening_q     <= dopen_q;
      closing_q     <= dclose_q;
      calibrating_q <= calib_q;
      status_q      <= status_val;
    end
  end

  assign in_stall_o        = (state_q != StIdle);
  assign out_valid_o       = out_valid_q;
  assign open_drive_o      = open_q;
  assign close_drive_o     = close_q;
  assign position_angle_o  = pos_q;
  assign estimated_angle_o = est_q;
  assign goal_angle_o      = goal_q;
  assign moving_o          = moving_q;
  assign is_opening_o      = opening_q;
  assign is_closing_o      = closing_q;
  assign is_calibrating_o  = calibrating_q;
  assign status_code_o     = status_q;

endmodule

/* rtl/tvpc_checker.sv */
module tvpc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      open_drive_o,
  input logic                      close_drive_o,
  input logic [tvpc_pkg::AngW-1:0] position_angle_o,
  input logic [tvpc_pkg::AngW-1:0] estimated_angle_o,
  input logic                      moving_o,
  input logic                      is_opening_o,
  input logic                      is_closing_o,
  input logic                      is_calibrating_o,
  input logic [2:0]                status_code_o
);
  import tvpc_pkg::*;

  // never drive both directions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(open_drive_o && close_drive_o))
    else $error("both motor drives active");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_calibrating_o) |-> (status_code_o == StatCal && !moving_o))
    else $error("calibration word has wrong status or motion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && moving_o) |-> (is_opening_o != is_closing_o))
    else $error("run without exactly one direction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !moving_o) |-> (estimated_angle_o == position_angle_o
                                    && !is_opening_o && !is_closing_o))
    else $error("idle word estimate differs from settled angle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(position_angle_o)))
    else $error("stalled output word changed");

endmodule

bind timed_valve_position_controller tvpc_checker u_tvpc_checker (.*);

/* verif/tb_timed_valve_position_controller.sv */
module tb_timed_valve_position_controller;
  import tvpc_pkg::*;

  localparam logic [2:0] CmdSpareA      = 3'd6;
  localparam logic [2:0] CmdSpareB      = 3'd7;
  localparam longint     TicksPerSecond = 1000;
  localparam int         AngleTop       = 360;
  localparam int         CycleLimit     = 4_000_000;

  typedef struct {
    logic            open_drv;
    logic            close_drv;
    logic [AngW-1:0] position;
    logic [AngW-1:0] estimate;
    logic [AngW-1:0] goal;
    logic            moving;
    logic            opening;
    logic            closing;
    logic            calibrating;
    logic [2:0]      status;
  } valve_report_t;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              psel              = 1'b0;
  logic              penable           = 1'b0;
  logic              pwrite            = 1'b0;
  logic [3:0]        paddr             = '0;
  logic [31:0]       pwdata            = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i        = 1'b0;
  logic              in_stall_o;
  logic [2:0]        cmd_i             = CmdTick;
  logic [AngW-1:0]   requested_angle_i = '0;
  logic              out_valid_o;
  logic              out_stall_i       = 1'b0;
  logic              open_drive_o;
  logic              close_drive_o;
  logic [AngW-1:0]   position_angle_o;
  logic [AngW-1:0]   estimated_angle_o;
  logic [AngW-1:0]   goal_angle_o;
  logic              moving_o;
  logic              is_opening_o;
  logic              is_closing_o;
  logic              is_calibrating_o;
  logic [2:0]        status_code_o;

  timed_valve_position_controller dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .requested_angle_i (requested_angle_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .open_drive_o      (open_drive_o),
    .close_drive_o     (close_drive_o),
    .position_angle_o  (position_angle_o),
    .estimated_angle_o (estimated_angle_o),
    .goal_angle_o      (goal_angle_o),
    .moving_o          (moving_o),
    .is_opening_o      (is_opening_o),
    .is_closing_o      (is_closing_o),
    .is_calibrating_o  (is_calibrating_o),
    .status_code_o     (status_code_o)
  );

  always #2 clk_i = ~clk_i;

  // valve state as the block should hold it
  logic [AngW-1:0]  cfg_start;
  logic [AngW-1:0]  cfg_max;
  logic [TravW-1:0] cfg_travel;
  logic             cfg_cal_cw;
  logic [AngW-1:0]  vlv_settled;
  logic [AngW-1:0]  vlv_target;
  logic [TimeW-1:0] vlv_elapsed;
  logic             vlv_moving;
  logic             vlv_open;
  logic             vlv_close;
  logic             vlv_cal;

  valve_report_t pending_reports[$];

  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int hold_left       = 0;
  int mismatches      = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int runs_settled    = 0;
  int cal_finished    = 0;

  function automatic void valve_reset();
    cfg_start   = StartReset;
    cfg_max     = MaxReset;
    cfg_travel  = TravelReset;
    cfg_cal_cw  = 1'b1;
    vlv_settled = '0;
    vlv_target  = '0;
    vlv_elapsed = '0;
    vlv_moving  = 1'b0;
    vlv_open    = 1'b0;
    vlv_close   = 1'b0;
    vlv_cal     = 1'b0;
  endfunction

  function automatic void cfg_store(reg_idx_e idx, logic [31:0] val);
    case (idx)
      RegStart:  cfg_start  = val[AngW-1:0];
      RegMax:    cfg_max    = val[AngW-1:0];
      RegTravel: cfg_travel = val[TravW-1:0];
      RegCalCw:  cfg_cal_cw = val[0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] cfg_value(reg_idx_e idx);
    case (idx)
      RegStart:  return 32'(cfg_start);
      RegMax:    return 32'(cfg_max);
      RegTravel: return 32'(cfg_travel);
      default:   return 32'(cfg_cal_cw);
    endcase
  endfunction

  function automatic longint angle_dist(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [AngW-1:0] half_point();
    int s;
    int m;
    int h;
    s = cfg_start;
    m = cfg_max;
    h = s + (m - s) / 2;
    return h[AngW-1:0];
  endfunction

  function automatic longint run_ticks();
    longint span;
    longint d;
    span = angle_dist(cfg_max, cfg_start);
    if (span == 0) return 0;
    d = angle_dist(vlv_settled, vlv_target) * cfg_travel * TicksPerSecond / span;
    return (d > TimeMax) ? longint'(TimeMax) : d;
  endfunction

  function automatic logic [AngW-1:0] estimate_angle();
    longint dur;
    longint diff;
    longint amt;
    longint q;
    longint v;
    longint tgt;
    if (!vlv_moving) return vlv_settled;
    dur  = run_ticks();
    diff = angle_dist(vlv_settled, vlv_target);
    tgt  = vlv_target;
    if (vlv_elapsed >= dur) begin
      amt = diff;
    end else begin
      q   = diff * vlv_elapsed;
      // opening rounds up, closing rounds down
      amt = vlv_open ? (q + dur - 1) / dur : q / dur;
    end
    v = vlv_settled;
    if (vlv_open) begin
      v = v - amt;
      if (v < tgt) v = tgt;
    end else begin
      v = v + amt;
      if (v > tgt) v = tgt;
    end
    return v[AngW-1:0];
  endfunction

  function automatic void valve_tick();
    longint lim;
    if ((vlv_moving || vlv_cal) && vlv_elapsed < TimeMax) vlv_elapsed++;
    if (!vlv_moving && !vlv_cal && vlv_settled != vlv_target) begin
      vlv_open    = vlv_settled > vlv_target;
      vlv_close   = !vlv_open;
      vlv_moving  = 1'b1;
      vlv_elapsed = '0;
    end
    if (vlv_cal) begin
      lim = cfg_travel;
      lim = (lim + 2) * TicksPerSecond;
      if (lim > TimeMax) lim = TimeMax;
      if (vlv_elapsed >= lim) begin
        vlv_cal     = 1'b0;
        vlv_settled = cfg_cal_cw ? cfg_start : cfg_max;
        cal_finished++;
      end
    end
    if (vlv_moving && vlv_elapsed >= run_ticks()) begin
      vlv_moving  = 1'b0;
      vlv_open    = 1'b0;
      vlv_close   = 1'b0;
      vlv_settled = vlv_target;
      runs_settled++;
    end
  endfunction

  function automatic valve_report_t valve_apply(logic [2:0] cmd, logic [AngW-1:0] ang);
    valve_report_t   r;
    logic [AngW-1:0] h;
    logic [AngW-1:0] req;
    case (cmd)
      CmdTick:  valve_tick();
      CmdOpen:  if (vlv_settled != cfg_start) vlv_target = cfg_start;
      CmdClose: if (vlv_settled != cfg_max) vlv_target = cfg_max;
      CmdHalf: begin
        h = half_point();
        if (vlv_settled != h) vlv_target = h;
      end
      CmdSetTarget: begin
        if (ang != vlv_target) begin
          req = ang;
          if (req < cfg_start) req = cfg_start;
          else if (req > cfg_max) req = cfg_max;
          vlv_target = req;
        end
      end
      CmdCalibrate: begin
        vlv_moving  = 1'b0;
        vlv_open    = 1'b0;
        vlv_close   = 1'b0;
        vlv_cal     = 1'b1;
        vlv_elapsed = '0;
      end
      default: ;
    endcase

    if (vlv_cal) r.status = StatCal;
    else if (vlv_moving) r.status = StatMoving;
    else if (vlv_settled == cfg_start) r.status = StatOpen;
    else if (vlv_settled == half_point()) r.status = StatHalf;
    else if (vlv_settled == cfg_max) r.status = StatClosed;
    else r.status = StatOther;

    r.open_drv    = (vlv_moving && vlv_open) || (vlv_cal && cfg_cal_cw);
    r.close_drv   = (vlv_moving && vlv_close) || (vlv_cal && !cfg_cal_cw);
    r.position    = vlv_settled;
    r.estimate    = estimate_angle();
    r.goal        = vlv_target;
    r.moving      = vlv_moving;
    r.opening     = vlv_open;
    r.closing     = vlv_close;
    r.calibrating = vlv_cal;
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result port: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin : result_check
    valve_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result word, nothing pending", $time);
      end else begin
        want = pending_reports.pop_front();
        results_checked++;
        check_field("open_drive", want.open_drv, open_drive_o);
        check_field("close_drive", want.close_drv, close_drive_o);
        check_field("position_angle", want.position, position_angle_o);
        check_field("estimated_angle", want.estimate, estimated_angle_o);
        check_field("goal_angle", want.goal, goal_angle_o);
        check_field("moving", want.moving, moving_o);
        check_field("is_opening", want.opening, is_opening_o);
        check_field("is_closing", want.closing, is_closing_o);
        check_field("is_calibrating", want.calibrating, is_calibrating_o);
        check_field("status_code", want.status, status_code_o);
      end
    end
  end

  // receiver: random stall, or a counted hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", CycleLimit,
             pending_reports.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_word(logic [2:0] cmd, logic [AngW-1:0] ang);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cmd_i             <= cmd;
    requested_angle_i <= ang;
    do @(posedge clk_i); while (in_stall_o);
    pending_reports.push_back(valve_apply(cmd, ang));
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_store(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(reg_idx_e idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", cfg_value(idx), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for the block to go quiet, then load and read back all four registers
  task automatic apply_setting(int s, int m, int t, int c);
    drain_results();
    apb_write(RegStart, 32'(s));
    apb_write(RegMax, 32'(m));
    apb_write(RegTravel, 32'(t));
    apb_write(RegCalCw, 32'(c));
    for (int i = 0; i < 4; i++) apb_read_check(reg_idx_e'(i));
  endtask

  function automatic logic [AngW-1:0] rand_angle();
    return AngW'($urandom_range(0, AngleTop));
  endfunction

  function automatic logic [AngW-1:0] near_angle();
    int a;
    a = vlv_settled;
    if ($urandom_range(1)) a = a + int'($urandom_range(1, 8));
    else a = a - int'($urandom_range(1, 8));
    if (a < 0) a = 0;
    if (a > AngleTop) a = AngleTop;
    return a[AngW-1:0];
  endfunction

  task automatic test_directed_commands();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_word(CmdTick, 9'd0);
    send_word(CmdSpareA, 9'd360);
    send_word(CmdSpareB, 9'd0);
    send_word(CmdOpen, 9'd0);
    send_word(CmdClose, 9'd255);
    send_word(CmdTick, 9'd256);
    send_word(CmdTick, 9'd0);
    send_word(CmdHalf, 9'd0);
    send_word(CmdTick, 9'd0);
    send_word(CmdSetTarget, 9'd360);
    send_word(CmdSetTarget, 9'd90);
    // target back onto the settled angle: the run ends on the next tick
    send_word(CmdSetTarget, 9'd0);
    send_word(CmdTick, 9'd0);
    send_word(CmdTick, 9'd0);
  endtask

  task automatic test_register_extremes();
    // reversed range: clamps land on the start angle
    apply_setting(360, 0, 255, 0);
    send_word(CmdSetTarget, 9'd100);
    send_word(CmdTick, 9'd0);
    send_word(CmdTick, 9'd0);
    send_word(CmdHalf, 9'd0);
    send_word(CmdTick, 9'd0);
    // zero range ends the running motion at once
    apply_setting(180, 180, 1, 0);
    send_word(CmdTick, 9'd0);
    send_word(CmdClose, 9'd0);
    apply_setting(0, 360, 1, 1);
    send_word(CmdTick, 9'd0);
    apply_setting(360, 360, 1, 1);
    send_word(CmdClose, 9'd0);
    send_word(CmdTick, 9'd0);
    apply_setting(0, 360, 1, 1);
    send_word(CmdTick, 9'd0);
    // narrow range with slow travel saturates the duration
    apply_setting(0, 1, 255, 1);
    send_word(CmdOpen, 9'd0);
    send_word(CmdTick, 9'd0);
    send_word(CmdTick, 9'd0);
    send_word(CmdTick, 9'd0);
  endtask

  task automatic test_calibration();
    send_idle_pct = 0;
    stall_pct     = 0;
    apply_setting(40, 320, 1, 1);
    send_word(CmdSetTarget, 9'd200);
    send_word(CmdTick, 9'd0);
    send_word(CmdTick, 9'd0);
    // cancel the run that is still going
    send_word(CmdCalibrate, 9'd0);
    repeat (20) send_word(CmdTick, rand_angle());
    send_word(CmdOpen, 9'd0);
    send_word(CmdSetTarget, 9'd100);
    repeat (10) send_word(CmdTick, rand_angle());
    apply_setting(40, 320, 1, 0);
    send_word(CmdCalibrate, 9'd0);
    repeat (20) send_word(CmdTick, rand_angle());
    // restart the calibration before it ends
    send_word(CmdCalibrate, 9'd0);
    repeat (10) send_word(CmdTick, rand_angle());
    // flip the drive direction mid-calibration and back again
    apply_setting(40, 320, 1, 1);
    repeat (10) send_word(CmdTick, rand_angle());
    apply_setting(40, 320, 1, 0);
    repeat (10) send_word(CmdTick, rand_angle());
  endtask

  // each round: at most one command, mostly a small move from the settled angle, then a burst of ticks
  task automatic run_random_phase(int n_items);
    int sent;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) send_word(CmdSetTarget, near_angle());
      else if (pick < 56) send_word(CmdOpen, rand_angle());
      else if (pick < 62) send_word(CmdClose, rand_angle());
      else if (pick < 66) send_word(CmdHalf, rand_angle());
      else if (pick < 72) send_word(CmdSetTarget, rand_angle());
      else if (pick < 75) send_word(pick[0] ? CmdSpareA : CmdSpareB, rand_angle());
      if (pick < 75) sent++;
      repeat ($urandom_range(1, 30)) begin
        send_word(CmdTick, rand_angle());
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;
    stall_pct     = 0;
    apply_setting(0, 360, 1, 1);
    run_random_phase(300);
    send_idle_pct = 79;
    apply_setting(50, 150, 1, 0);
    run_random_phase(300);
    send_idle_pct = 0;
    stall_pct     = 79;
    apply_setting(10, 350, 1, 0);
    run_random_phase(300);
    send_idle_pct = 38;
    stall_pct     = 38;
    apply_setting(0, 360, 1, 1);
    run_random_phase(200);
    apply_setting(123, 123, 7, 1);
    run_random_phase(60);
    apply_setting(200, 180, 1, 0);
    run_random_phase(60);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    apply_setting(0, 360, 1, 1);
    @(posedge clk_i);
    hold_left = 400;
    repeat (8) begin
      send_word(CmdSetTarget, near_angle());
      send_word(CmdTick, rand_angle());
    end
    while (hold_left > 0) @(posedge clk_i);
    // hold the sender until every result is back
    drain_results();
    repeat (10) send_word(CmdTick, rand_angle());
  endtask

  initial begin
    valve_reset();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_commands();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    test_calibration();
    drain_results();
    repeat (100) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      mismatches++;
      $display("%0t %0d predicted results never arrived", $time, pending_reports.size());
    end
    $display("sent %0d command words, checked %0d result words", words_sent,
             results_checked);
    $display("valve settled after %0d timed runs, %0d calibrations ran to the end stop",
             runs_settled, cal_finished);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
